[hdl/clipped_box_mean_filter_core_defines.svh]
// assertion macros for the clipped box mean filter
`ifndef CLIPPED_BOX_MEAN_FILTER_CORE_DEFINES_SVH
`define CLIPPED_BOX_MEAN_FILTER_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define CBMF_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);
`define CBMF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);
`else
`define CBMF_ASSERT_SAME(lbl, ante, cons, msg)
`define CBMF_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[hdl/cbmf_pkg.sv]
// shared types and constants of the clipped box mean filter
`default_nettype none
package cbmf_pkg;
  localparam int unsigned DefMaxWidth = 1024;
  localparam int unsigned DefMaxHalf  = 3;
  localparam int unsigned HalfRegW    = 2;
  localparam int unsigned DimRegW     = 11;
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned PixW        = 8;

  localparam logic [CfgIdxW-1:0] CFG_WINDOW_HALF  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_IMAGE_WIDTH  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_IMAGE_HEIGHT = 2'd2;

  localparam logic [HalfRegW-1:0] RstHalf   = 2'd2;
  localparam logic [DimRegW-1:0]  RstWidth  = 11'd640;
  localparam logic [DimRegW-1:0]  RstHeight = 11'd480;

  typedef struct packed {
    logic ld_item;
    logic clr_cnt;
    logic start_win;
    logic rd_issue;
    logic div_start;
    logic div_step;
    logic out_take;
  } cbmf_cmd_t;

  typedef struct packed {
    logic skip;
    logic clr;
    logic no_result;
    logic rd_last;
    logic div_done;
  } cbmf_sts_t;
endpackage
`default_nettype wire

[hdl/cbmf_datapath.sv]
// counters, line store, window accumulators and dividers
`default_nettype none
module cbmf_datapath
  import cbmf_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = DefMaxWidth,
  parameter int unsigned MAX_HALF  = DefMaxHalf
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [DimRegW-1:0]  cfg_wdata_i,
  input  wire logic [PixW-1:0]     red_in_i,
  input  wire logic [PixW-1:0]     green_in_i,
  input  wire logic [PixW-1:0]     blue_in_i,
  input  wire logic                flush_i,
  input  wire cbmf_cmd_t           cmd_i,
  output cbmf_sts_t                sts_o,
  output logic [PixW-1:0]          red_out_o,
  output logic [PixW-1:0]          green_out_o,
  output logic [PixW-1:0]          blue_out_o,
  output logic                     frame_end_o
);
  localparam int unsigned ColW   = $clog2(MAX_WIDTH);
  localparam int unsigned WW     = ColW + 1;
  localparam int unsigned RowW   = DimRegW;
  localparam int unsigned HalfW  = $clog2(MAX_HALF + 1);
  localparam int unsigned SlotW  = $clog2(2 * MAX_HALF + 2);
  localparam int unsigned AddrW  = SlotW + ColW;
  localparam int unsigned Depth  = 1 << AddrW;
  localparam int unsigned LinW   = WW + RowW;
  localparam int unsigned DimW   = $clog2(2 * MAX_HALF + 2);
  localparam int unsigned CntW   = 2 * DimW;
  localparam int unsigned SumW   = PixW + CntW;
  localparam int unsigned DcntW  = $clog2(SumW + 1);

  logic [HalfRegW-1:0] half_q;
  logic [DimRegW-1:0]  width_q, height_q;
  logic [WW-1:0]       w_eff;
  logic [HalfW-1:0]    h_eff;
  logic [RowW-1:0]     hgt_eff;
  logic [LinW-1:0]     total, lag;

  logic [RowW-1:0] in_row_q, out_row_q;
  logic [ColW-1:0] in_col_q, out_col_q;
  logic [LinW-1:0] in_lin_q, out_lin_q;
  logic            skip_q;
  logic            in_done, wr_en, frame_end;

  logic [RowW-1:0] rr_q, r1_q, r0_d, r1_d;
  logic [ColW-1:0] cc_q, c0_q, c1_q, c0_d, c1_d;
  logic [DimW-1:0] rows_q, cols_q;
  logic [CntW-1:0] cnt;
  logic            rd_vld_q;
  logic [3*PixW-1:0] rd_data_q;
  logic [3*PixW-1:0] mem_q [Depth];

  logic [SumW-1:0] sum_q [3];
  logic [SumW-1:0] num_q [3];
  logic [CntW-1:0] rem_q [3];
  logic [DcntW-1:0] dcnt_q;

  always_comb begin
    if (width_q == '0) begin
      w_eff = WW'(1);
    end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_q);
    end
    if (32'(half_q) > 32'(MAX_HALF)) begin
      h_eff = HalfW'(MAX_HALF);
    end else begin
      h_eff = HalfW'(half_q);
    end
    hgt_eff = (height_q == '0) ? RowW'(1) : height_q;
  end

  assign total     = LinW'(w_eff) * LinW'(hgt_eff);
  assign lag       = LinW'(h_eff) * LinW'(w_eff) + LinW'(h_eff);
  assign in_done   = in_row_q >= hgt_eff;
  assign wr_en     = cmd_i.ld_item && !in_done && !flush_i;
  assign frame_end = (out_lin_q + LinW'(1)) == total;
  assign cnt       = CntW'(rows_q) * CntW'(cols_q);

  // clipped window bounds
  always_comb begin
    logic [RowW:0] rsum;
    logic [WW:0]   csum;
    rsum = {1'b0, out_row_q} + (RowW + 1)'(h_eff);
    csum = (WW + 1)'(out_col_q) + (WW + 1)'(h_eff);
    r0_d = (out_row_q >= RowW'(h_eff)) ? out_row_q - RowW'(h_eff) : '0;
    r1_d = (rsum < (RowW + 1)'(hgt_eff)) ? RowW'(rsum) : hgt_eff - RowW'(1);
    c0_d = (out_col_q >= ColW'(h_eff)) ? out_col_q - ColW'(h_eff) : '0;
    c1_d = (csum < (WW + 1)'(w_eff)) ? ColW'(csum) : ColW'(w_eff - WW'(1));
  end

  assign sts_o.skip      = skip_q;
  assign sts_o.clr       = out_lin_q >= total;
  assign sts_o.no_result = !in_done && (in_lin_q <= out_lin_q + lag);
  assign sts_o.rd_last   = (cc_q == c1_q) && (rr_q == r1_q);
  assign sts_o.div_done  = dcnt_q == DcntW'(SumW - 1);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[{in_row_q[SlotW-1:0], in_col_q}] <= {red_in_i, green_in_i, blue_in_i};
    end
    if (cmd_i.rd_issue) begin
      rd_data_q <= mem_q[{rr_q[SlotW-1:0], cc_q}];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q    <= RstHalf;
      width_q   <= RstWidth;
      height_q  <= RstHeight;
      in_row_q  <= '0;
      in_col_q  <= '0;
      in_lin_q  <= '0;
      out_row_q <= '0;
      out_col_q <= '0;
      out_lin_q <= '0;
      skip_q    <= 1'b0;
      rd_vld_q  <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.rd_issue;
      if (cmd_i.ld_item) begin
        skip_q <= !in_done && flush_i;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_WINDOW_HALF:  half_q   <= cfg_wdata_i[HalfRegW-1:0];
          CFG_IMAGE_WIDTH:  width_q  <= cfg_wdata_i;
          CFG_IMAGE_HEIGHT: height_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if ((cfg_we_i && (cfg_idx_i == CFG_WINDOW_HALF || cfg_idx_i == CFG_IMAGE_WIDTH ||
           cfg_idx_i == CFG_IMAGE_HEIGHT)) || cmd_i.clr_cnt ||
          (cmd_i.out_take && frame_end)) begin
        in_row_q  <= '0;
        in_col_q  <= '0;
        in_lin_q  <= '0;
        out_row_q <= '0;
        out_col_q <= '0;
        out_lin_q <= '0;
      end else begin
        if (wr_en) begin
          in_lin_q <= in_lin_q + LinW'(1);
          if (WW'(in_col_q) + WW'(1) >= w_eff) begin
            in_col_q <= '0;
            in_row_q <= in_row_q + RowW'(1);
          end else begin
            in_col_q <= in_col_q + ColW'(1);
          end
        end
        if (cmd_i.out_take) begin
          out_lin_q <= out_lin_q + LinW'(1);
          if (WW'(out_col_q) + WW'(1) >= w_eff) begin
            out_col_q <= '0;
            out_row_q <= out_row_q + RowW'(1);
          end else begin
            out_col_q <= out_col_q + ColW'(1);
          end
        end
      end
    end
  end

  // window walk, accumulation and restoring division
  always_ff @(posedge clk_i) begin
    if (cmd_i.start_win) begin
      rr_q   <= r0_d;
      r1_q   <= r1_d;
      cc_q   <= c0_d;
      c0_q   <= c0_d;
      c1_q   <= c1_d;
      rows_q <= DimW'(r1_d - r0_d + RowW'(1));
      cols_q <= DimW'(c1_d - c0_d + ColW'(1));
    end else if (cmd_i.rd_issue) begin
      if (cc_q == c1_q) begin
        cc_q <= c0_q;
        rr_q <= rr_q + RowW'(1);
      end else begin
        cc_q <= cc_q + ColW'(1);
      end
    end
    if (cmd_i.div_start) begin
      dcnt_q <= '0;
    end else if (cmd_i.div_step) begin
      dcnt_q <= dcnt_q + DcntW'(1);
    end
    for (int ch = 0; ch < 3; ch++) begin
      logic [CntW:0] trial;
      trial = {rem_q[ch], num_q[ch][SumW-1]};
      if (cmd_i.start_win) begin
        sum_q[ch] <= '0;
      end else if (rd_vld_q) begin
        sum_q[ch] <= sum_q[ch] + SumW'(rd_data_q[PixW*(2-ch) +: PixW]);
      end
      if (cmd_i.div_start) begin
        num_q[ch] <= sum_q[ch];
        rem_q[ch] <= '0;
      end else if (cmd_i.div_step) begin
        if (trial >= {1'b0, cnt}) begin
          rem_q[ch] <= CntW'(trial - {1'b0, cnt});
          num_q[ch] <= {num_q[ch][SumW-2:0], 1'b1};
        end else begin
          rem_q[ch] <= CntW'(trial);
          num_q[ch] <= {num_q[ch][SumW-2:0], 1'b0};
        end
      end
    end
  end

  assign red_out_o   = num_q[0][PixW-1:0];
  assign green_out_o = num_q[1][PixW-1:0];
  assign blue_out_o  = num_q[2][PixW-1:0];
  assign frame_end_o = frame_end;
endmodule
`default_nettype wire

[hdl/cbmf_ctrl.sv]
// sequencer for item intake, window walk, division and result handoff
`default_nettype none
`include "clipped_box_mean_filter_core_defines.svh"
module cbmf_ctrl
  import cbmf_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  input  wire logic      out_stall_i,
  input  wire cbmf_sts_t sts_i,
  output cbmf_cmd_t      cmd_o,
  output logic           in_stall_o,
  output logic           out_valid_o
);
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_READ   = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_LOAD   = 3'd4;
  localparam logic [2:0] S_DIV    = 3'd5;
  localparam logic [2:0] S_OUT    = 3'd6;

  logic [2:0] state_q, state_d;

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = state_q == S_OUT;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.ld_item = 1'b1;
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts_i.skip) begin
          state_d = S_IDLE;
        end else if (sts_i.clr) begin
          cmd_o.clr_cnt = 1'b1;
          state_d = S_IDLE;
        end else if (sts_i.no_result) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.start_win = 1'b1;
          state_d = S_READ;
        end
      end
      S_READ: begin
        cmd_o.rd_issue = 1'b1;
        if (sts_i.rd_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: state_d = S_LOAD;
      S_LOAD: begin
        cmd_o.div_start = 1'b1;
        state_d = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_stall_i) begin
          cmd_o.out_take = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `CBMF_ASSERT_SAME(a_out_blocks_in, out_valid_o, in_stall_o, "result pending while taking items")
  `CBMF_ASSERT_NEXT(a_read_to_drain, state_q == S_READ && sts_i.rd_last, state_q == S_DRAIN, "window walk did not end")
  `CBMF_ASSERT_NEXT(a_div_to_out, state_q == S_DIV && sts_i.div_done, out_valid_o, "division did not hand off")
endmodule
`default_nettype wire

[hdl/clipped_box_mean_filter_core.sv]
// top level of the clipped box mean filter
//
//   channel | handshake                  | payload
//   in      | in_valid_i / in_stall_o    | red_in_i green_in_i blue_in_i flush_i
//   out     | out_valid_o / out_stall_i  | red_out_o green_out_o blue_out_o frame_end_o
//   cfg     | cfg_we_i                   | cfg_idx_i cfg_wdata_i
//
// an item that gives a result takes longer as the clipped window grows, as the
// line store has a single read port and the divider is bit-serial; a result
// is held while out_stall_i is high
// reset clears counters and loads config defaults; the line store is not cleared
// in_stall_o is high from an accepted item until its result is taken or none is due
`default_nettype none
module clipped_box_mean_filter_core
  import cbmf_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = DefMaxWidth,
  parameter int unsigned MAX_HALF  = DefMaxHalf
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [DimRegW-1:0] cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [PixW-1:0]    red_in_i,
  input  wire logic [PixW-1:0]    green_in_i,
  input  wire logic [PixW-1:0]    blue_in_i,
  input  wire logic               flush_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [PixW-1:0]         red_out_o,
  output logic [PixW-1:0]         green_out_o,
  output logic [PixW-1:0]         blue_out_o,
  output logic                    frame_end_o
);
  cbmf_cmd_t cmd;
  cbmf_sts_t sts;

  cbmf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o)
  );

  cbmf_datapath #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HALF  (MAX_HALF)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .red_in_i    (red_in_i),
    .green_in_i  (green_in_i),
    .blue_in_i   (blue_in_i),
    .flush_i     (flush_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .red_out_o   (red_out_o),
    .green_out_o (green_out_o),
    .blue_out_o  (blue_out_o),
    .frame_end_o (frame_end_o)
  );
endmodule
`default_nettype wire
